FILE: src/sfs_pkg.sv
// Shared types and constants for the sorted-table floor search block.
// Holds field widths, register and command codes, and the controller/datapath
// command and status structs. No dependencies.
`default_nettype none

package sfs_pkg;

	localparam int KEY_W   = 32;
	localparam int SLOT_W  = 13;
	localparam int INDEX_W = 13;
	localparam int COUNT_W = 14;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// operation codes of an input item
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// register index, taken from paddr[PADDR_W-1:2]
	localparam logic [PADDR_W-3:0] REG_ENTRY_COUNT = 1'b0;

	typedef enum logic [1:0] {
		ADDR_SLOT,
		ADDR_FIRST,
		ADDR_LAST,
		ADDR_MID
	} addr_sel_t;

	typedef enum logic [1:0] {
		RES_EMPTY,
		RES_ZERO,
		RES_LAST,
		RES_FLOOR
	} res_sel_t;

	typedef struct packed {
		logic      load_query;
		logic      write_entry;
		addr_sel_t addr_sel;
		logic      init_bounds;
		logic      step_bounds;
		logic      load_result;
		res_sel_t  res_sel;
		logic      load_output;
	} sfs_cmd_t;

	typedef struct packed {
		logic count_zero;
		logic count_one;
		logic key_le_data;
		logic key_ge_data;
		logic bounds_open;
	} sfs_status_t;

endpackage

`default_nettype wire

FILE: src/sfs_stream_if.sv
// Valid/ready stream interfaces for query items and result items.
// Depends on sfs_pkg for the field widths.
`default_nettype none

interface sfs_query_if
	import sfs_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic                     op;
	logic [SLOT_W-1:0]        entry_slot;
	logic signed [KEY_W-1:0]  key_value;

	modport source (output valid, output op, output entry_slot, output key_value, input ready);
	modport sink   (input valid, input op, input entry_slot, input key_value, output ready);
endinterface

interface sfs_result_if
	import sfs_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [INDEX_W-1:0] found_index;
	logic               empty_error;

	modport source (output valid, output found_index, output empty_error, input ready);
	modport sink   (input valid, input found_index, input empty_error, output ready);
endinterface

`default_nettype wire

FILE: src/sfs_ram.sv
// Generic single-port RAM with registered read data.
// No package dependency.
`default_nettype none

module sfs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8192
) (
	input  wire logic                                        clk,
	input  wire logic                                        we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  wire logic [WIDTH-1:0]                            wdata,
	output      logic [WIDTH-1:0]                            rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;
endmodule

`default_nettype wire

FILE: src/sfs_regs.sv
// APB-style configuration register bank: holds entry_count.
// Depends on sfs_pkg for widths and the register index.
`default_nettype none

module sfs_regs
	import sfs_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output      logic [PDATA_W-1:0] prdata,
	output      logic               pready,
	output      logic [COUNT_W-1:0] entry_count
);
	logic [COUNT_W-1:0] entry_count_q;
	logic               hit_count;

	assign hit_count = (paddr[PADDR_W-1:2] == REG_ENTRY_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (psel && penable && pwrite && hit_count) begin
			entry_count_q <= pwdata[COUNT_W-1:0];
		end
	end

	assign prdata      = hit_count ? PDATA_W'(entry_count_q) : '0;
	assign pready      = 1'b1;
	assign entry_count = entry_count_q;
endmodule

`default_nettype wire

FILE: src/sfs_datapath.sv
// Datapath: key table RAM, query key and count, bisection bounds and the
// pending and output result registers. Depends on sfs_pkg and sfs_ram.
`default_nettype none

module sfs_datapath
	import sfs_pkg::*;
#(
	parameter int TABLE_DEPTH = 8192
) (
	input  wire logic                     clk,
	input  wire sfs_cmd_t                 cmd,
	output      sfs_status_t              status,
	input  wire logic [COUNT_W-1:0]       entry_count,
	input  wire logic [SLOT_W-1:0]        entry_slot,
	input  wire logic signed [KEY_W-1:0]  key_value,
	output      logic [INDEX_W-1:0]       found_index,
	output      logic                     empty_error
);
	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int NW = $clog2(TABLE_DEPTH + 1);

	logic [NW-1:0]           n_d;
	logic [NW-1:0]           n_q;
	logic signed [KEY_W-1:0] key_q;
	logic [IW-1:0]           lo_q, hi_q, mid_q;
	logic [IW-1:0]           lo_n, hi_n, mid_n;
	logic [IW-1:0]           last_idx;
	logic [IW-1:0]           ram_addr;
	logic                    ram_we;
	logic                    slot_ok;
	logic signed [KEY_W-1:0] rd_data;
	logic [KEY_W-1:0]        rd_raw;
	logic                    data_gt;
	logic [INDEX_W-1:0]      res_index_d, res_index_q;
	logic                    res_empty_d, res_empty_q;
	logic [INDEX_W-1:0]      out_index_q;
	logic                    out_empty_q;

	// saturate the programmed count to the table depth
	assign n_d = (32'(entry_count) > 32'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : NW'(entry_count);

	assign last_idx = IW'(n_q - NW'(1));
	assign slot_ok  = (32'(entry_slot) < 32'(TABLE_DEPTH));
	assign ram_we   = cmd.write_entry && slot_ok;
	assign rd_data  = signed'(rd_raw);
	assign data_gt  = (rd_data > key_q);

	always_comb begin
		if (cmd.init_bounds) begin
			lo_n = '0;
			hi_n = last_idx;
		end else if (cmd.step_bounds) begin
			lo_n = data_gt ? lo_q : IW'(mid_q + IW'(1));
			hi_n = data_gt ? mid_q : hi_q;
		end else begin
			lo_n = lo_q;
			hi_n = hi_q;
		end
		mid_n = IW'(lo_n + ((hi_n - lo_n) >> 1));
	end

	always_comb begin
		unique case (cmd.addr_sel)
			ADDR_SLOT:  ram_addr = IW'(entry_slot);
			ADDR_FIRST: ram_addr = '0;
			ADDR_LAST:  ram_addr = last_idx;
			ADDR_MID:   ram_addr = mid_n;
		endcase
	end

	sfs_ram #(
		.WIDTH (KEY_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (key_value),
		.rdata (rd_raw)
	);

	always_comb begin
		unique case (cmd.res_sel)
			RES_EMPTY: begin
				res_index_d = '0;
				res_empty_d = 1'b1;
			end
			RES_ZERO: begin
				res_index_d = '0;
				res_empty_d = 1'b0;
			end
			RES_LAST: begin
				res_index_d = INDEX_W'(last_idx);
				res_empty_d = 1'b0;
			end
			RES_FLOOR: begin
				res_index_d = INDEX_W'(IW'(lo_n - IW'(1)));
				res_empty_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_query) begin
			key_q <= key_value;
			n_q   <= n_d;
		end
		if (cmd.init_bounds || cmd.step_bounds) begin
			lo_q  <= lo_n;
			hi_q  <= hi_n;
			mid_q <= mid_n;
		end
		if (cmd.load_result) begin
			res_index_q <= res_index_d;
			res_empty_q <= res_empty_d;
		end
		if (cmd.load_output) begin
			out_index_q <= res_index_q;
			out_empty_q <= res_empty_q;
		end
	end

	assign status.count_zero  = (n_d == '0);
	assign status.count_one   = (n_d == NW'(1));
	assign status.key_le_data = (key_q <= rd_data);
	assign status.key_ge_data = (key_q >= rd_data);
	assign status.bounds_open = (lo_n < hi_n);

	assign found_index = out_index_q;
	assign empty_error = out_empty_q;
endmodule

`default_nettype wire

FILE: src/sfs_ctrl.sv
// Controller state machine: sequences table writes, the edge checks and the
// bisection probes, and owns the output valid flag. Depends on sfs_pkg.
`default_nettype none

module sfs_ctrl
	import sfs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_op,
	output      logic        in_ready,
	output      logic        out_valid,
	input  wire logic        out_ready,
	output      sfs_cmd_t    cmd,
	input  wire sfs_status_t status
);
	typedef enum logic [5:0] {
		S_IDLE        = 6'b000001,
		S_FETCH_FIRST = 6'b000010,
		S_TEST_FIRST  = 6'b000100,
		S_TEST_LAST   = 6'b001000,
		S_BISECT      = 6'b010000,
		S_DONE        = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   in_fire;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.addr_sel = ADDR_SLOT;
				if (in_fire) begin
					if (in_op == OP_WRITE) begin
						cmd.write_entry = 1'b1;
					end else begin
						cmd.load_query = 1'b1;
						priority if (status.count_zero) begin
							cmd.load_result = 1'b1;
							cmd.res_sel     = RES_EMPTY;
							state_d         = S_DONE;
						end else if (status.count_one) begin
							cmd.load_result = 1'b1;
							cmd.res_sel     = RES_ZERO;
							state_d         = S_DONE;
						end else begin
							state_d = S_FETCH_FIRST;
						end
					end
				end
			end
			S_FETCH_FIRST: begin
				cmd.addr_sel = ADDR_FIRST;
				state_d      = S_TEST_FIRST;
			end
			S_TEST_FIRST: begin
				cmd.addr_sel = ADDR_LAST;
				if (status.key_le_data) begin
					cmd.load_result = 1'b1;
					cmd.res_sel     = RES_ZERO;
					state_d         = S_DONE;
				end else begin
					state_d = S_TEST_LAST;
				end
			end
			S_TEST_LAST: begin
				cmd.addr_sel = ADDR_MID;
				if (status.key_ge_data) begin
					cmd.load_result = 1'b1;
					cmd.res_sel     = RES_LAST;
					state_d         = S_DONE;
				end else begin
					cmd.init_bounds = 1'b1;
					state_d         = S_BISECT;
				end
			end
			S_BISECT: begin
				cmd.addr_sel    = ADDR_MID;
				cmd.step_bounds = 1'b1;
				if (!status.bounds_open) begin
					cmd.load_result = 1'b1;
					cmd.res_sel     = RES_FLOOR;
					state_d         = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_output = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_output) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
endmodule

`default_nettype wire

FILE: src/sorted_table_floor_search.sv
// Sorted-table floor search: a table of signed 32-bit keys written in
// ascending order, searched by bisection for the last entry not above a key.
// A write item (op 0) stores key_value at entry_slot; slots at or beyond
// TABLE_DEPTH are dropped. A query item (op 1) returns found_index, the
// index of the last entry whose key does not exceed key_value, clamped to 0
// and to entry_count-1, with empty_error set when entry_count is 0. The table
// lives in one single-port RAM with registered read, so each probe is one
// registered read: a query with a count of 0 or 1 goes from its transfer
// straight to the hand-over state; otherwise the first and last entries are
// checked (fetch, test-first and test-last states), then one bisection step
// per cycle, at most ceil(log2(count)) steps, and the hand-over state moves
// the result to the output register once the result side is free. The
// output register holds a finished result while the next item is taken.
// Table contents are undefined after reset and there is no clearing pass;
// entries inside entry_count must be written before a query.
// entry_count (reset 0, saturated to TABLE_DEPTH) sits at APB byte address 0.
// Depends on sfs_pkg, the stream interfaces, sfs_regs, sfs_ctrl, sfs_datapath.
`default_nettype none

module sorted_table_floor_search
	import sfs_pkg::*;
#(
	parameter int TABLE_DEPTH = 8192
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	sfs_query_if.sink               query,
	sfs_result_if.source            result,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output      logic [PDATA_W-1:0] prdata,
	output      logic               pready
);
	logic               in_ready;
	logic               out_valid;
	logic [COUNT_W-1:0] entry_count;
	logic [INDEX_W-1:0] found_index;
	logic               empty_error;
	sfs_cmd_t           cmd;
	sfs_status_t        status;

	// configuration: entry_count, to be written by the user only while the block is idle; not enforced by the block
	sfs_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.entry_count (entry_count)
	);

	// sequence writes, edge checks and bisection; own the result valid flag
	sfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (query.valid),
		.in_op     (query.op),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (result.ready),
		.cmd       (cmd),
		.status    (status)
	);

	// key table, bounds and result registers
	sfs_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk         (clk),
		.cmd         (cmd),
		.status      (status),
		.entry_count (entry_count),
		.entry_slot  (query.entry_slot),
		.key_value   (query.key_value),
		.found_index (found_index),
		.empty_error (empty_error)
	);

	assign query.ready        = in_ready;
	assign result.valid       = out_valid;
	assign result.found_index = found_index;
	assign result.empty_error = empty_error;
endmodule

`default_nettype wire

FILE: src/sfs_checker.sv
// Port-level checker for the floor search block, bound to the top level.
// Depends on sfs_pkg for field widths and op codes.
`default_nettype none

module sfs_checker
	import sfs_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               q_valid,
	input wire logic               q_ready,
	input wire logic               q_op,
	input wire logic               r_valid,
	input wire logic               r_ready,
	input wire logic [INDEX_W-1:0] r_found_index,
	input wire logic               r_empty_error
);
	// a stalled result stays offered
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> r_valid)
		else $error("result valid dropped while stalled");

	// a stalled result keeps its payload
	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> $stable(r_found_index) && $stable(r_empty_error))
		else $error("result payload changed while stalled");

	// an empty-table result carries index zero
	a_empty_index: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && r_empty_error |-> r_found_index == '0)
		else $error("empty_error with nonzero index");

	// a query transfer leaves the input side busy in the cycle after it
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid && q_ready && q_op == OP_QUERY |=> !q_ready)
		else $error("input ready right after a query transfer");

	// a new result is only raised while the input side is busy
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(r_valid) |-> !$past(q_ready))
		else $error("result appeared without a query in flight");
endmodule

bind sorted_table_floor_search sfs_checker u_sfs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.q_valid       (query.valid),
	.q_ready       (query.ready),
	.q_op          (query.op),
	.r_valid       (result.valid),
	.r_ready       (result.ready),
	.r_found_index (result.found_index),
	.r_empty_error (result.empty_error)
);

`default_nettype wire
